// File: rtl/clook_pkg.sv
// Shared types, codes and defaults for the C-LOOK disk request scheduler.
package clook_pkg;

    // Default number of queue entries
    localparam int QUEUE_DEPTH_DEF = 64;

    // Command codes on the input item
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_SERVE = 1'b1;

    // Status codes on the result item
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Sweep direction
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // One queued request
    typedef struct packed {
        logic [15:0] track;
        logic [7:0]  tag;
    } entry_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_START,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_SRV_START,
        ST_SRV_SCAN,
        ST_SRV_SHRD,
        ST_SRV_SHWR,
        ST_DONE
    } state_t;

endpackage

// File: rtl/clook_disk_request_scheduler.sv
// Top level of the C-LOOK disk request scheduler: sequencer, queue RAM and result register.
// The block keeps up to QUEUE_DEPTH requests in a RAM sorted by ascending track and
// handles one item at a time; in_stall is high while an item is being worked on. An add
// compares the queued entries with the new track from the top down, moves each entry at
// or above it up by one and then writes the new request into the gap. A serve takes an
// entry that qualifies in the current direction: the scan reads up to the chosen entry
// and the entries behind it are then shifted down one per cycle. When an upward sweep
// finds nothing and turns round, the scan covers the whole queue first and the lowest
// entry is served. An add on a full queue and a serve on an empty queue go straight to
// the result. The result moves into the output register once that register is free,
// which waits while an earlier result is still held there under out_stall. The sequencer
// returns to idle before the next item can be accepted. The single read port of the
// queue RAM and the shared track comparator handle one entry per cycle. A finished result
// waits in the output register while the next item is accepted. The queue RAM needs no
// clearing after reset: only entries below the fill count are ever read.
module clook_disk_request_scheduler #(
    parameter int QUEUE_DEPTH = clook_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [15:0] req_track,
    input  logic [7:0]  req_id,
    input  logic [15:0] arm_track,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  served_id,
    output logic [15:0] served_track,
    output logic [6:0]  pending
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    clook_pkg::state_t state_reg, state_next;
    clook_pkg::dir_t   dir_reg, dir_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [15:0]       last_reg, last_next;
    clook_pkg::entry_t first_reg, first_next;

    logic [15:0] trk_reg;
    logic [7:0]  tag_reg;
    logic [15:0] arm_reg;

    logic [1:0]  res_status_reg, res_status_next;
    logic [7:0]  res_id_reg, res_id_next;
    logic [15:0] res_track_reg, res_track_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg;
    logic [7:0]  out_id_reg;
    logic [15:0] out_track_reg;
    logic [6:0]  out_pending_reg;
    logic        out_load;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    clook_pkg::entry_t wr_data;
    logic [AW-1:0]     rd_addr;
    clook_pkg::entry_t rd_data;

    logic [15:0] cmp_a, cmp_b;
    logic        cmp_ge;
    logic [CW:0] idx_p1, idx_p2;
    logic        in_acc;

    assign in_acc = in_valid && !in_stall;
    assign in_stall = (state_reg != clook_pkg::ST_IDLE);

    assign idx_p1 = {1'b0, idx_reg} + (CW+1)'(1);
    assign idx_p2 = {1'b0, idx_reg} + (CW+1)'(2);

    // Shared track comparator
    assign cmp_ge = (cmp_a >= cmp_b);

    // Queue storage
    clook_ram #(
        .WIDTH($bits(clook_pkg::entry_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= clook_pkg::ST_IDLE;
            dir_reg       <= clook_pkg::DIR_NONE;
            count_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dir_reg       <= dir_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_track_reg  <= res_track_next;
        if (in_acc)
        begin
            trk_reg <= req_track;
            tag_reg <= req_id;
            arm_reg <= arm_track;
        end
        if (out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_id_reg      <= res_id_reg;
            out_track_reg   <= res_track_reg;
            out_pending_reg <= 7'(count_reg);
        end
    end

    // Sequencer: next state, RAM access and result
    always_comb
    begin
        state_next      = state_reg;
        dir_next        = dir_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        last_next       = last_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_track_next  = res_track_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[AW-1:0];
        wr_data         = rd_data;
        rd_addr         = '0;
        cmp_a           = rd_data.track;
        cmp_b           = trk_reg;
        out_load        = 1'b0;

        unique case (state_reg)
            clook_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (cmd == clook_pkg::CMD_ADD) ? clook_pkg::ST_INS_START
                                                             : clook_pkg::ST_SRV_START;
                end
            end

            clook_pkg::ST_INS_START:
            begin
                res_id_next    = '0;
                res_track_next = '0;
                if (count_reg == CW'(QUEUE_DEPTH))
                begin
                    res_status_next = clook_pkg::STATUS_FULL;
                    state_next      = clook_pkg::ST_DONE;
                end
                else
                begin
                    res_status_next = clook_pkg::STATUS_OK;
                    idx_next        = count_reg;
                    if (count_reg == '0)
                    begin
                        state_next = clook_pkg::ST_INS_PUT;
                    end
                    else
                    begin
                        rd_addr    = AW'(count_reg - CW'(1));
                        state_next = clook_pkg::ST_INS_CMP;
                    end
                end
            end

            // Move entries at or above the new track up by one
            clook_pkg::ST_INS_CMP:
            begin
                cmp_a = rd_data.track;
                cmp_b = trk_reg;
                if (cmp_ge)
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data;
                    idx_next = idx_reg - CW'(1);
                    if (idx_reg == CW'(1))
                    begin
                        state_next = clook_pkg::ST_INS_PUT;
                    end
                    else
                    begin
                        rd_addr = AW'(idx_reg - CW'(2));
                    end
                end
                else
                begin
                    state_next = clook_pkg::ST_INS_PUT;
                end
            end

            // Drop the new request into the gap and set direction
            clook_pkg::ST_INS_PUT:
            begin
                wr_en         = 1'b1;
                wr_data.track = trk_reg;
                wr_data.tag   = tag_reg;
                count_next    = count_reg + CW'(1);
                if (count_reg == '0)
                begin
                    if (arm_reg < trk_reg)
                    begin
                        dir_next = clook_pkg::DIR_UP;
                    end
                    else if (arm_reg > trk_reg)
                    begin
                        dir_next = clook_pkg::DIR_DOWN;
                    end
                    else
                    begin
                        dir_next = clook_pkg::DIR_NONE;
                    end
                end
                else if (dir_reg == clook_pkg::DIR_NONE)
                begin
                    dir_next = (arm_reg < trk_reg) ? clook_pkg::DIR_UP : clook_pkg::DIR_DOWN;
                end
                state_next = clook_pkg::ST_DONE;
            end

            clook_pkg::ST_SRV_START:
            begin
                res_id_next    = '0;
                res_track_next = '0;
                idx_next       = '0;
                if (count_reg == '0)
                begin
                    res_status_next = clook_pkg::STATUS_EMPTY;
                    state_next      = clook_pkg::ST_DONE;
                end
                else
                begin
                    res_status_next = clook_pkg::STATUS_OK;
                    rd_addr         = '0;
                    state_next      = clook_pkg::ST_SRV_SCAN;
                end
            end

            // Pick the entry to serve
            clook_pkg::ST_SRV_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    first_next = rd_data;
                end
                if (dir_reg == clook_pkg::DIR_DOWN)
                begin
                    // Downward always serves the lowest entry; flip if it lies above
                    cmp_a          = last_reg;
                    cmp_b          = rd_data.track;
                    dir_next       = cmp_ge ? clook_pkg::DIR_DOWN : clook_pkg::DIR_UP;
                    res_id_next    = rd_data.tag;
                    res_track_next = rd_data.track;
                    last_next      = rd_data.track;
                    state_next     = clook_pkg::ST_SRV_SHRD;
                end
                else
                begin
                    cmp_a = rd_data.track;
                    cmp_b = last_reg;
                    if (cmp_ge)
                    begin
                        dir_next       = clook_pkg::DIR_UP;
                        res_id_next    = rd_data.tag;
                        res_track_next = rd_data.track;
                        last_next      = rd_data.track;
                        state_next     = clook_pkg::ST_SRV_SHRD;
                    end
                    else if (idx_p1 == {1'b0, count_reg})
                    begin
                        // Nothing above: flip and take the lowest entry
                        dir_next = clook_pkg::DIR_DOWN;
                        idx_next = '0;
                        if (idx_reg == '0)
                        begin
                            res_id_next    = rd_data.tag;
                            res_track_next = rd_data.track;
                            last_next      = rd_data.track;
                        end
                        else
                        begin
                            res_id_next    = first_reg.tag;
                            res_track_next = first_reg.track;
                            last_next      = first_reg.track;
                        end
                        state_next = clook_pkg::ST_SRV_SHRD;
                    end
                    else
                    begin
                        rd_addr  = idx_p1[AW-1:0];
                        idx_next = idx_p1[CW-1:0];
                    end
                end
            end

            // Start closing the gap behind the served entry
            clook_pkg::ST_SRV_SHRD:
            begin
                if (idx_p1 < {1'b0, count_reg})
                begin
                    rd_addr    = idx_p1[AW-1:0];
                    state_next = clook_pkg::ST_SRV_SHWR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = clook_pkg::ST_DONE;
                end
            end

            // Shift entries down by one
            clook_pkg::ST_SRV_SHWR:
            begin
                wr_en    = 1'b1;
                wr_data  = rd_data;
                idx_next = idx_p1[CW-1:0];
                if (idx_p2 < {1'b0, count_reg})
                begin
                    rd_addr = idx_p2[AW-1:0];
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = clook_pkg::ST_DONE;
                end
            end

            // Hand the result to the output register once it is free
            clook_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = clook_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = clook_pkg::ST_IDLE;
            end
        endcase
    end

    // Output valid: hold until taken, set on a new result
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign served_id    = out_id_reg;
    assign served_track = out_track_reg;
    assign pending      = out_pending_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == clook_pkg::ST_INS_CMP || state_reg == clook_pkg::ST_INS_PUT ||
         state_reg == clook_pkg::ST_SRV_SCAN || state_reg == clook_pkg::ST_SRV_SHWR)
        |-> idx_reg <= count_reg)
        else $error("queue index beyond fill count");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == clook_pkg::ST_INS_CMP || state_reg == clook_pkg::ST_INS_PUT ||
                   state_reg == clook_pkg::ST_SRV_SHWR))
        else $error("queue write outside an add or serve");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != clook_pkg::STATUS_OK)
        |-> (out_id_reg == '0 && out_track_reg == '0))
        else $error("error result carries a served request");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(state_reg == clook_pkg::ST_INS_PUT ||
                                               state_reg == clook_pkg::ST_SRV_SHRD ||
                                               state_reg == clook_pkg::ST_SRV_SHWR))
        else $error("fill count changed outside an insert or removal");
`endif

endmodule

// File: rtl/clook_ram.sv
// Generic single-write, single-read RAM with registered read data.
module clook_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
